[hw/rtl/assert_macros.svh]
// Assertion macros shared by the list controller and datapath.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define PAL_ASSERT_NEVER(label, cond, msg) \
  `PAL_ASSERT(label, !(cond), msg)

`endif

[hw/rtl/pal_pkg.sv]
// Shared types and constants of the positional array list.
// Used by pal_ctrl, pal_dp and the top level; depends on nothing else.
package pal_pkg;

  // Default store depth and fixed field widths.
  localparam int CAPACITY_DEF = 128;
  localparam int OP_W         = 2;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 8;
  localparam int ST_W         = 2;

  // Request operations.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_UP_DRAIN,
    S_UP_VAL,
    S_DN,
    S_DN_DRAIN,
    S_FIND,
    S_FIND_LAST
  } state_t;

  // Next value of the walking address register.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT_M1,
    IDX_POS_P1,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd;
    logic     shift_up;
    logic     shift_dn;
    idx_sel_t idx_sel;
    logic     wr_val;
    logic     wr_at_pos;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     done;
    logic     find;
    status_t  status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_eq_cnt;
    logic pos_ge_cnt;
    logic pos_is_last;
    logic idx_at_pos;
    logic idx_at_last;
    logic hit;
  } sts_t;

endpackage

[hw/rtl/pal_ctrl.sv]
// Controller state machine of the positional array list.
// Depends on pal_pkg and assert_macros.svh; drives the commands of pal_dp.
`include "assert_macros.svh"

module pal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output pal_pkg::cmd_t cmd,
  input  pal_pkg::sts_t sts
);
  import pal_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.idx_sel = IDX_HOLD;
    cmd.status  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_APPEND: begin
            state_nxt = S_IDLE;
            cmd.done  = 1'b1;
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.wr_val  = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_INSERT: begin
            priority if (sts.full) begin
              cmd.done   = 1'b1;
              cmd.status = ST_FULL;
              state_nxt  = S_IDLE;
            end else if (sts.pos_gt_cnt) begin
              cmd.done   = 1'b1;
              cmd.status = ST_BADPOS;
              state_nxt  = S_IDLE;
            end else if (sts.pos_eq_cnt) begin
              // Insert at the end is an append at the given position.
              cmd.wr_val    = 1'b1;
              cmd.wr_at_pos = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.done      = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              cmd.idx_sel = IDX_CNT_M1;
              state_nxt   = S_UP;
            end
          end
          OP_DELETE: begin
            priority if (sts.empty) begin
              cmd.done   = 1'b1;
              cmd.status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end else if (sts.pos_ge_cnt) begin
              cmd.done   = 1'b1;
              cmd.status = ST_BADPOS;
              state_nxt  = S_IDLE;
            end else if (sts.pos_is_last) begin
              // Removing the last entry moves nothing.
              cmd.cnt_dec = 1'b1;
              cmd.done    = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.idx_sel = IDX_POS_P1;
              state_nxt   = S_DN;
            end
          end
          OP_FIND: begin
            if (sts.empty) begin
              cmd.done  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = S_FIND;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // Walk down from the top entry, moving each one up by one place.
      S_UP: begin
        cmd.rd       = 1'b1;
        cmd.shift_up = 1'b1;
        if (sts.idx_at_pos) begin
          state_nxt = S_UP_DRAIN;
        end else begin
          cmd.idx_sel = IDX_DEC;
        end
      end
      S_UP_DRAIN: begin
        state_nxt = S_UP_VAL;
      end
      S_UP_VAL: begin
        cmd.wr_val    = 1'b1;
        cmd.wr_at_pos = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.done      = 1'b1;
        state_nxt     = S_IDLE;
      end
      // Walk up from the entry after the removed position, moving each entry down by one.
      S_DN: begin
        cmd.rd       = 1'b1;
        cmd.shift_dn = 1'b1;
        if (sts.idx_at_last) begin
          state_nxt = S_DN_DRAIN;
        end else begin
          cmd.idx_sel = IDX_INC;
        end
      end
      S_DN_DRAIN: begin
        cmd.cnt_dec = 1'b1;
        cmd.done    = 1'b1;
        state_nxt   = S_IDLE;
      end
      // Read one entry a cycle and compare the one read the cycle before.
      S_FIND: begin
        if (sts.hit) begin
          cmd.find  = 1'b1;
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          if (sts.idx_at_last) begin
            state_nxt = S_FIND_LAST;
          end else begin
            cmd.idx_sel = IDX_INC;
          end
        end
      end
      S_FIND_LAST: begin
        cmd.find  = 1'b1;
        cmd.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A finished item always returns the controller to idle.
  `PAL_ASSERT(a_done_to_idle, cmd.done |=> state_r == S_IDLE, "done did not return to idle")
  // Busy only drops right after an item was finished.
  `PAL_ASSERT(a_busy_fall, $fell(busy) |-> $past(cmd.done), "busy dropped without a result")
  // An accepted item always starts with its decode cycle.
  `PAL_ASSERT(a_accept_decode, start && !busy |=> state_r == S_DECODE, "accept missed decode")

endmodule

[hw/rtl/pal_dp.sv]
// Datapath of the positional array list: entry memory, count, walk address and result registers.
// Depends on pal_pkg and assert_macros.svh; commanded by pal_ctrl.
`include "assert_macros.svh"

module pal_dp #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pal_pkg::cmd_t                    cmd,
  output pal_pkg::sts_t                    sts,
  input  logic        [pal_pkg::OP_W-1:0]  in_op,
  input  logic        [pal_pkg::POS_W-1:0] in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  output logic        [pal_pkg::ST_W-1:0]  out_status,
  output logic        [pal_pkg::POS_W-1:0] out_found_position,
  output logic        [pal_pkg::LEN_W-1:0] out_list_length
);
  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int PX = PW + 1;

  // Latched request.
  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  // List state and walk registers.
  logic [VAL_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    idx_nxt;
  logic [VAL_W-1:0] rdata_r;
  logic [AW-1:0]    rd_idx_r;
  logic             rd_vld_r;
  logic             wr_pend_r;
  logic             wr_up_r;

  // Result registers.
  logic             out_valid_r;
  status_t          status_r;
  logic [POS_W-1:0] found_r;
  logic [LEN_W-1:0] len_r;

  logic [PW-1:0]    pos_x;
  logic [PW-1:0]    cnt_x;
  logic             hit;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    pend_addr;
  logic [VAL_W-1:0] wr_data;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      pos_r <= in_position;
      val_r <= in_item_value;
    end
  end

  // Status toward the controller.
  assign pos_x = PW'(pos_r);
  assign cnt_x = PW'(cnt_r);
  assign hit   = rd_vld_r && (rdata_r == val_r);

  always_comb begin
    sts             = '0;
    sts.op          = op_r;
    sts.full        = (cnt_r == CW'(CAPACITY));
    sts.empty       = (cnt_r == '0);
    sts.pos_gt_cnt  = (pos_x > cnt_x);
    sts.pos_eq_cnt  = (pos_x == cnt_x);
    sts.pos_ge_cnt  = (pos_x >= cnt_x);
    sts.pos_is_last = ((PX'(pos_x) + PX'(1)) == PX'(cnt_x));
    sts.idx_at_pos  = (PW'(idx_r) == pos_x);
    sts.idx_at_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
    sts.hit         = hit;
  end

  // Walk address and entry count.
  always_comb begin
    unique case (cmd.idx_sel)
      IDX_HOLD:   idx_nxt = idx_r;
      IDX_CNT_M1: idx_nxt = AW'(cnt_r - CW'(1));
      IDX_POS_P1: idx_nxt = AW'(pos_r) + AW'(1);
      IDX_ZERO:   idx_nxt = '0;
      IDX_INC:    idx_nxt = idx_r + AW'(1);
      IDX_DEC:    idx_nxt = idx_r - AW'(1);
      default:    idx_nxt = idx_r;
    endcase
    priority if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      wr_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= cmd.rd;
      wr_pend_r <= cmd.rd && (cmd.shift_up || cmd.shift_dn);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.rd) begin
      rd_idx_r <= idx_r;
      wr_up_r  <= cmd.shift_up;
    end
  end

  // Write port: a moved entry lands one place above or below where it was read,
  // otherwise the request value goes to its position or to the end.
  assign pend_addr = wr_up_r ? (rd_idx_r + AW'(1)) : (rd_idx_r - AW'(1));
  assign wr_en     = wr_pend_r || cmd.wr_val;
  assign wr_addr   = wr_pend_r     ? pend_addr   :
                     cmd.wr_at_pos ? AW'(pos_r)  : AW'(cnt_r);
  assign wr_data   = wr_pend_r ? rdata_r : val_r;

  // Entry memory with one registered read port and one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= entries_r[idx_r];
    end
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
  end

  // Result registers, shown for one cycle after the item finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status_r <= cmd.status;
      found_r  <= (cmd.find && hit) ? POS_W'(CW'(rd_idx_r) + CW'(1)) : '0;
      len_r    <= LEN_W'(cnt_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_list_length    = len_r;

  // The value write never competes with a pending moved entry.
  `PAL_ASSERT_NEVER(a_wr_collide, wr_pend_r && cmd.wr_val, "write port collision")
  // The count never exceeds the store depth.
  `PAL_ASSERT_NEVER(a_cnt_range, cnt_r > CW'(CAPACITY), "count beyond capacity")
  // Growing the list only happens when there is room.
  `PAL_ASSERT_NEVER(a_grow_full, cmd.cnt_inc && sts.full, "grew a full list")

endmodule

[hw/rtl/positional_array_list.sv]
// Top level of the positional array list: a bounded list kept densely in one memory.
// Depends on pal_pkg, pal_ctrl and pal_dp.
//
// Usage: drive in_op, in_position and in_item_value and raise start; the item is
// taken at the clock edge where start is high and busy is low. Append adds at the
// end, insert and delete shift the later entries, find reports the 1-based place
// of the first equal value (0 when absent). Each item gives one result, held on
// out_status, out_found_position and out_list_length for the single cycle in
// which out_valid is high; the receiver cannot stall it.
// Append, insert at the end, refused requests, deleting the last entry and find on
// an empty list finish in their decode step. Any other insert walks the entries
// from the position up, any other delete those above it, and find walks from the
// first entry until it hits or passes the last. The entry walk goes through the
// memory's one read port, one entry per cycle. busy falls in the cycle the result
// is shown, so the next item can be taken at the edge that ends it.
// Reset (rst_n low, synchronous) empties the list; entries need no clearing.
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic        [pal_pkg::OP_W-1:0]  in_op,
  input  logic        [pal_pkg::POS_W-1:0] in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  output logic        [pal_pkg::ST_W-1:0]  out_status,
  output logic        [pal_pkg::POS_W-1:0] out_found_position,
  output logic        [pal_pkg::LEN_W-1:0] out_list_length
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Memory, count and result registers.
  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

endmodule
